// File: src/rvmt_pkg.sv
// rvmt_pkg: shared types and constants for the row-vector by 4x4 matrix transform.
// Used by rvmt_cell, rvmt_clamp and row_vector_matrix_transform_unit.
`timescale 1ns / 1ps

package rvmt_pkg;

   localparam int COORD_W   = 32;              // Q16.16 word
   localparam int FRAC_W    = 16;
   localparam int PROD_W    = 2 * COORD_W;     // exact Q32.32 product
   localparam int SUM_W     = PROD_W + 2;      // sum of four products, no loss
   localparam int NUM_COLS  = 4;
   localparam int NUM_ROWS  = 4;
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_W     = 64;

   localparam logic [COORD_W-1:0] ONE_Q16   = 32'h0001_0000;
   localparam logic [COORD_W-1:0] SAT_MAX   = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_MIN   = 32'h8000_0000;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_A  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_B  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_A  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_B  = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW3_A  = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW3_B  = 8'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_A = 8'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_B = 8'd7;

   // Identity matrix after reset.
   localparam logic [CSR_W-1:0] RST_ROW1_A  = {32'h0, ONE_Q16};
   localparam logic [CSR_W-1:0] RST_ROW1_B  = '0;
   localparam logic [CSR_W-1:0] RST_ROW2_A  = {ONE_Q16, 32'h0};
   localparam logic [CSR_W-1:0] RST_ROW2_B  = '0;
   localparam logic [CSR_W-1:0] RST_ROW3_A  = '0;
   localparam logic [CSR_W-1:0] RST_ROW3_B  = {32'h0, ONE_Q16};
   localparam logic [CSR_W-1:0] RST_TRANS_A = '0;
   localparam logic [CSR_W-1:0] RST_TRANS_B = {ONE_Q16, 32'h0};

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef coord_type [NUM_COLS-1:0]  vec_type;
   typedef prod_type  [NUM_COLS-1:0]  prodvec_type;
   typedef sum_type   [NUM_COLS-1:0]  sumvec_type;

   // Side data that travels with a word down the chain.
   typedef struct packed {
      logic point;
   } tag_type;

endpackage

// File: src/rvmt_cell.sv
// rvmt_cell: one matrix row of the transform chain; multiply, then accumulate.
// Depends on rvmt_pkg.
`timescale 1ns / 1ps

module rvmt_cell (
   input  logic                clock,
   input  logic                en_p,
   input  logic                en_s,
   input  rvmt_pkg::vec_type    coef,
   input  rvmt_pkg::vec_type    comp_in,
   input  rvmt_pkg::tag_type    tag_in,
   input  rvmt_pkg::sumvec_type sum_in,
   output rvmt_pkg::vec_type    comp_out,
   output rvmt_pkg::tag_type    tag_p_out,
   output rvmt_pkg::sumvec_type sum_out,
   output rvmt_pkg::tag_type    tag_s_out
);
   import rvmt_pkg::*;

   vec_type     comp_ff;
   tag_type     tag_p_ff;
   prodvec_type prod_ff;
   prodvec_type prod_in;
   sumvec_type  sum_ff;
   sumvec_type  sum_in_nxt;
   tag_type     tag_s_ff;

   // This cell uses element 0; the rest move down one place for the next cell.
   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         prod_in[c] = $signed(comp_in[0]) * $signed(coef[c]);
         sum_in_nxt[c] = $signed(sum_in[c]) + SUM_W'($signed(prod_ff[c]));
      end
   end

   always_ff @(posedge clock) begin
      if (en_p) begin
         for (int c = 0; c < NUM_COLS - 1; c++) begin
            comp_ff[c] <= comp_in[c + 1];
         end
         comp_ff[NUM_COLS-1] <= '0;
         tag_p_ff <= tag_in;
         prod_ff  <= prod_in;
      end
      if (en_s) begin
         sum_ff   <= sum_in_nxt;
         tag_s_ff <= tag_p_ff;
      end
   end

   assign comp_out  = comp_ff;
   assign tag_p_out = tag_p_ff;
   assign sum_out   = sum_ff;
   assign tag_s_out = tag_s_ff;

endmodule

// File: src/rvmt_clamp.sv
// rvmt_clamp: floor to Q16.16, saturate and register the result word.
// Depends on rvmt_pkg.
`timescale 1ns / 1ps

module rvmt_clamp (
   input  logic                clock,
   input  logic                en,
   input  rvmt_pkg::sumvec_type sum_in,
   input  rvmt_pkg::tag_type    tag_in,
   output rvmt_pkg::vec_type    res_out,
   output logic                sat_out,
   output rvmt_pkg::tag_type    tag_out
);
   import rvmt_pkg::*;

   localparam int Q_W = SUM_W - FRAC_W;

   vec_type                res_in;
   logic [NUM_COLS-1:0]    clip;
   logic                   sat_in;
   vec_type                res_ff;
   logic                   sat_ff;
   tag_type                tag_ff;
   logic [Q_W-1:0]         q;

   always_comb begin
      q = '0;
      for (int c = 0; c < NUM_COLS; c++) begin
         q = sum_in[c][SUM_W-1:FRAC_W];  // floor by shift
         clip[c] = !((&q[Q_W-1:COORD_W-1]) || !(|q[Q_W-1:COORD_W-1]));
         if (clip[c]) begin
            res_in[c] = q[Q_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            res_in[c] = q[COORD_W-1:0];
         end
      end
      // point mode: w column reads zero and stays out of the flag
      if (tag_in.point) begin
         res_in[NUM_COLS-1] = '0;
         sat_in = |clip[NUM_COLS-2:0];
      end else begin
         sat_in = |clip;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
         tag_ff <= tag_in;
      end
   end

   assign res_out = res_ff;
   assign sat_out = sat_ff;
   assign tag_out = tag_ff;

endmodule

// File: src/row_vector_matrix_transform_unit.sv
// Top level of the row-vector by 4x4 matrix transform.
// Depends on rvmt_pkg, rvmt_cell and rvmt_clamp.
`timescale 1ns / 1ps

// Computes (x y z w) * M in signed Q16.16, one result word per request word.
// M is held in eight 64-bit registers, two coefficients each, low word first:
// index 0..5 are rows one to three, 6..7 the translation row; reset gives the
// identity, and writes to an index above 7 are dropped. Write them only while
// the unit is empty. In point mode (req_kind = 1) w is replaced by 1.0, out_w
// reads zero and w does not count toward rsp_saturated. Each column sum is
// kept exact, floored to Q16.16 and clamped to the signed 32-bit range.
// Throughput is one word per clock unless rsp_ready holds the output back.
// The datapath is a chain of four cells, one per matrix row, each with four
// 32x32 multipliers and a two-register multiply/accumulate step that overlaps
// with its neighbor, followed by a clamp register. Every register level has
// its own valid bit and advances when the level after it is empty or moving,
// so bubbles close up and a word is taken while a result waits on rsp_ready
// until all six levels are full.

module row_vector_matrix_transform_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  rvmt_pkg::coord_type                req_in_x,
   input  rvmt_pkg::coord_type                req_in_y,
   input  rvmt_pkg::coord_type                req_in_z,
   input  rvmt_pkg::coord_type                req_in_w,
   // response
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rvmt_pkg::coord_type                rsp_out_x,
   output rvmt_pkg::coord_type                rsp_out_y,
   output rvmt_pkg::coord_type                rsp_out_z,
   output rvmt_pkg::coord_type                rsp_out_w,
   output logic                              rsp_saturated,
   // configuration
   input  logic                              csr_write_en,
   input  logic [rvmt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rvmt_pkg::CSR_W-1:0]        csr_wdata
);
   import rvmt_pkg::*;

   localparam int NUM_LVL = NUM_ROWS + 2;   // cell levels plus clamp register
   localparam int REG_SEL_W = $clog2(NUM_REGS);

   // ---------------- configuration registers ----------------
   logic [CSR_W-1:0] csr_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff[REG_ROW1_A[REG_SEL_W-1:0]]  <= RST_ROW1_A;
         csr_ff[REG_ROW1_B[REG_SEL_W-1:0]]  <= RST_ROW1_B;
         csr_ff[REG_ROW2_A[REG_SEL_W-1:0]]  <= RST_ROW2_A;
         csr_ff[REG_ROW2_B[REG_SEL_W-1:0]]  <= RST_ROW2_B;
         csr_ff[REG_ROW3_A[REG_SEL_W-1:0]]  <= RST_ROW3_A;
         csr_ff[REG_ROW3_B[REG_SEL_W-1:0]]  <= RST_ROW3_B;
         csr_ff[REG_TRANS_A[REG_SEL_W-1:0]] <= RST_TRANS_A;
         csr_ff[REG_TRANS_B[REG_SEL_W-1:0]] <= RST_TRANS_B;
      end else if (csr_write_en && (csr_index <= REG_TRANS_B)) begin
         csr_ff[csr_index[REG_SEL_W-1:0]] <= csr_wdata;
      end
   end

   // coefficient (row r, column c) lives in register 2r + c/2, word c%2
   vec_type coef [NUM_ROWS];

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            coef[r][c] = csr_ff[REG_SEL_W'(2 * r + c / 2)][COORD_W * (c % 2) +: COORD_W];
         end
      end
   end

   // ---------------- pipeline flow control ----------------
   // level k (1..NUM_LVL) valid; en[k] loads level k
   logic [NUM_LVL:1]   vld_ff;
   logic [NUM_LVL:1]   vld_in;
   logic [NUM_LVL+1:1] en;

   always_comb begin
      en[NUM_LVL+1] = rsp_ready;
      for (int k = NUM_LVL; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[1] = en[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= NUM_LVL; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[1];
   assign rsp_valid = vld_ff[NUM_LVL];

   // ---------------- cell chain ----------------
   vec_type    comp_chain  [NUM_ROWS+1];
   tag_type    tag_p_chain [NUM_ROWS+1];
   sumvec_type sum_chain   [NUM_ROWS+1];
   tag_type    tag_s_chain [NUM_ROWS+1];

   assign comp_chain[0][0] = req_in_x;
   assign comp_chain[0][1] = req_in_y;
   assign comp_chain[0][2] = req_in_z;
   assign comp_chain[0][3] = req_kind ? coord_type'(ONE_Q16) : req_in_w;  // implied w
   assign tag_p_chain[0].point = req_kind;
   assign sum_chain[0]   = '0;
   assign tag_s_chain[0] = '0;

   for (genvar i = 0; i < NUM_ROWS; i++) begin : g_cell
      rvmt_cell u_cell (
         .clock     (clock),
         .en_p      (en[i+1]),
         .en_s      (en[i+2]),
         .coef      (coef[i]),
         .comp_in   (comp_chain[i]),
         .tag_in    (tag_p_chain[i]),
         .sum_in    (sum_chain[i]),
         .comp_out  (comp_chain[i+1]),
         .tag_p_out (tag_p_chain[i+1]),
         .sum_out   (sum_chain[i+1]),
         .tag_s_out (tag_s_chain[i+1])
      );
   end

   // ---------------- floor, clamp, result register ----------------
   vec_type res;
   tag_type res_tag;

   rvmt_clamp u_clamp (
      .clock   (clock),
      .en      (en[NUM_LVL]),
      .sum_in  (sum_chain[NUM_ROWS]),
      .tag_in  (tag_s_chain[NUM_ROWS]),
      .res_out (res),
      .sat_out (rsp_saturated),
      .tag_out (res_tag)
   );

   assign rsp_out_x = res[0];
   assign rsp_out_y = res[1];
   assign rsp_out_z = res[2];
   assign rsp_out_w = res[3];

`ifndef SYNTH
   // point-mode results always carry a zero w
   a_point_w_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && res_tag.point) |-> (rsp_out_w == '0))
      else $error("point-mode result with nonzero w");

   // the request side only stalls when every level is full and the output is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && (&vld_ff)))
      else $error("request stalled with room in the pipeline");

   // a saturated result must show at least one clamp value
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_out_x == SAT_MAX || rsp_out_x == SAT_MIN ||
          rsp_out_y == SAT_MAX || rsp_out_y == SAT_MIN ||
          rsp_out_z == SAT_MAX || rsp_out_z == SAT_MIN ||
          rsp_out_w == SAT_MAX || rsp_out_w == SAT_MIN))
      else $error("saturation flag without a clamped component");

   // an accepted word reaches the first level on the next cycle
   a_accept_lvl1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[1])
      else $error("accepted word lost at the first level");
`endif

endmodule
